@@ sv/mma_pkg.sv @@
// Shared types, constants and helpers for the multipole moment accumulator.
`default_nettype none

package mma_pkg;

  localparam int FRAC_BITS = 16;

  localparam int IN_W   = 32;
  localparam int SUM_W  = 64;
  localparam int LIMB_W = 32;
  localparam int MAG_W  = 2 * LIMB_W;
  localparam int PROD_W = 2 * MAG_W;
  localparam int OP_W   = MAG_W + 1;

  // Scaled density stays below 2^(63-FRAC_BITS); each rounded square below 2^(64-FRAC_BITS).
  localparam int Q_W  = 65 - FRAC_BITS;
  localparam int R_W  = IN_W + 1;
  localparam int D2_W = 67 - FRAC_BITS;

  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Z     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_VOLUME       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_DENSITY_MODE = 3'd4;

  localparam logic [IN_W-1:0] VOLUME_RESET = 32'd65536;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic                   start;
    logic signed [OP_W-1:0] a;
    logic signed [OP_W-1:0] b;
    logic                   a_wide;
    logic                   b_wide;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] res;
    logic             sat;
  } mul_rsp_t;

  // Saturating signed add; result is {saturated, sum}.
  function automatic logic [SUM_W:0] add_sat(input logic [SUM_W-1:0] a,
                                             input logic [SUM_W-1:0] b);
    logic [SUM_W-1:0] s;
    logic             ovf;
    s   = a + b;
    ovf = (a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1]);
    if (ovf) begin
      return {1'b1, (a[SUM_W-1] ? SUM_MIN : SUM_MAX)};
    end
    return {1'b0, s};
  endfunction

endpackage

`default_nettype wire

@@ sv/mma_mul.sv @@
// Shared multiplier: 32x32 partial products, round to nearest, saturate to 64 bits.
`default_nettype none

module mma_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mma_pkg::mul_req_t req_i,
  output mma_pkg::mul_rsp_t      rsp_o
);

  import mma_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MUL,
    PH_FIN
  } phase_e;

  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam int MAG_OUT_W = PROD_W - FRAC_BITS;

  phase_e            phase_q;
  logic [1:0]        step_q, step_d;
  logic [MAG_W-1:0]  a_q, b_q;
  logic              neg_q, a_wide_q, b_wide_q;
  logic [PROD_W-1:0] acc_q;
  mul_rsp_t          rsp_q;

  logic [MAG_W-1:0]     a_mag, b_mag;
  logic [LIMB_W-1:0]    a_limb, b_limb;
  logic [MAG_W-1:0]     pp;
  logic [PROD_W-1:0]    pp_shift;
  logic                 last_step;
  logic [MAG_OUT_W-1:0] mag;
  logic [SUM_W-1:0]     mag_lo, limit, res;
  logic                 sat;

  always_comb begin
    a_mag = req_i.a[OP_W-1] ? MAG_W'(-req_i.a) : MAG_W'(req_i.a);
    b_mag = req_i.b[OP_W-1] ? MAG_W'(-req_i.b) : MAG_W'(req_i.b);

    a_limb = step_q[1] ? a_q[MAG_W-1:LIMB_W] : a_q[LIMB_W-1:0];
    b_limb = step_q[0] ? b_q[MAG_W-1:LIMB_W] : b_q[LIMB_W-1:0];
    pp     = MAG_W'(a_limb) * MAG_W'(b_limb);

    case (step_q)
      2'b00:   pp_shift = PROD_W'(pp);
      2'b11:   pp_shift = PROD_W'(pp) << (2 * LIMB_W);
      default: pp_shift = PROD_W'(pp) << LIMB_W;
    endcase

    // Visit only the limb pairs that can be nonzero.
    last_step = 1'b1;
    step_d    = step_q;
    case (step_q)
      2'b00: begin
        if (b_wide_q) begin
          step_d    = 2'b01;
          last_step = 1'b0;
        end else if (a_wide_q) begin
          step_d    = 2'b10;
          last_step = 1'b0;
        end
      end
      2'b01: begin
        if (a_wide_q) begin
          step_d    = 2'b10;
          last_step = 1'b0;
        end
      end
      2'b10: begin
        if (b_wide_q) begin
          step_d    = 2'b11;
          last_step = 1'b0;
        end
      end
      default: ;
    endcase

    // The rounding half was preloaded into the accumulator.
    mag    = acc_q[PROD_W-1:FRAC_BITS];
    mag_lo = mag[SUM_W-1:0];
    limit  = neg_q ? SUM_MIN : SUM_MAX;
    sat    = (|mag[MAG_OUT_W-1:SUM_W]) || (mag_lo > limit);
    if (sat) begin
      res = neg_q ? SUM_MIN : SUM_MAX;
    end else begin
      res = neg_q ? -mag_lo : mag_lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= 2'b00;
      rsp_q   <= '0;
    end else begin
      rsp_q.done <= 1'b0;
      unique case (phase_q)
        PH_IDLE: begin
          if (req_i.start) begin
            step_q  <= 2'b00;
            phase_q <= PH_MUL;
          end
        end
        PH_MUL: begin
          step_q <= step_d;
          if (last_step) begin
            phase_q <= PH_FIN;
          end
        end
        PH_FIN: begin
          rsp_q.done <= 1'b1;
          rsp_q.res  <= res;
          rsp_q.sat  <= sat;
          phase_q    <= PH_IDLE;
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == PH_IDLE && req_i.start) begin
      a_q      <= a_mag;
      b_q      <= b_mag;
      neg_q    <= req_i.a[OP_W-1] ^ req_i.b[OP_W-1];
      a_wide_q <= req_i.a_wide;
      b_wide_q <= req_i.b_wide;
      acc_q    <= HALF;
    end else if (phase_q == PH_MUL) begin
      acc_q <= acc_q + pp_shift;
    end
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

@@ sv/multipole_moment_accumulator_top.sv @@
// Top level of the multipole moment accumulator: sequencer, sums and stream ports.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata charge, x, y, z; tlast ends the set
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata five 64-bit sums; tuser saturated
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_addr_i register index, cfg_data_i value
//
// Every product of an item runs through one shared 32x32 multiplier, which visits only
// the limb pairs that can be nonzero; density mode adds the volume product first.
// A last item also loads the output register in the emit step, waiting while it is full.
// Reset clears the sums, the flag and the registers to their defaults; no clearing pass.
// The input side is not ready while an item is in progress; cfg is always ready.
`default_nettype none

module multipole_moment_accumulator_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // charge_or_density [31:0], pos_x [63:32], pos_y [95:64], pos_z [127:96]
  input  wire logic [4*mma_pkg::IN_W-1:0]     s_axis_tdata,
  input  wire logic                           s_axis_tlast,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // total_charge [63:0], dipole_x [127:64], dipole_y [191:128], dipole_z [255:192],
  // quadrupole_trace [319:256]
  output logic [5*mma_pkg::SUM_W-1:0]         m_axis_tdata,
  // saturated [0]
  output logic                                m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [mma_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [mma_pkg::IN_W-1:0]       cfg_data_i
);

  import mma_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QMUL,
    S_CHG,
    S_SQ,
    S_DIP,
    S_TR,
    S_EMIT
  } state_e;

  // Configuration
  logic signed [IN_W-1:0] origin_q [3];
  logic [IN_W-1:0]        volume_q;
  logic                   density_q;

  // Sequencer and sums
  state_e           state_q;
  logic [1:0]       idx_q;
  logic             issued_q;
  logic [SUM_W-1:0] charge_q, trace_q;
  logic [SUM_W-1:0] dip_q [3];
  logic             sat_q;
  logic             last_q;

  // Item operands
  logic signed [IN_W-1:0] cd_q;
  logic signed [R_W-1:0]  r_q [3];
  logic signed [Q_W-1:0]  q_q;
  logic [D2_W-1:0]        d2_q;

  // Output register
  logic [5*SUM_W-1:0] out_data_q;
  logic               out_sat_q;
  logic               out_valid_q;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic                  accept;
  logic                  in_mul_state;
  logic signed [R_W-1:0] r_sel;
  logic [SUM_W-1:0]      dip_sel;
  logic [SUM_W-1:0]      add_a, add_b;
  logic [SUM_W:0]        add_res;
  logic                  emit_go;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign emit_go       = !out_valid_q || m_axis_tready;

  always_comb begin
    case (idx_q)
      2'd1:    begin r_sel = r_q[1]; dip_sel = dip_q[1]; end
      2'd2:    begin r_sel = r_q[2]; dip_sel = dip_q[2]; end
      default: begin r_sel = r_q[0]; dip_sel = dip_q[0]; end
    endcase
  end

  always_comb begin
    in_mul_state = (state_q inside {S_QMUL, S_SQ, S_DIP, S_TR});
    mul_req       = '0;
    mul_req.start = in_mul_state && !issued_q;
    unique case (state_q)
      S_QMUL: begin
        mul_req.a = OP_W'(cd_q);
        mul_req.b = OP_W'({1'b0, volume_q});
      end
      S_SQ: begin
        mul_req.a = OP_W'(r_sel);
        mul_req.b = OP_W'(r_sel);
      end
      S_DIP: begin
        mul_req.a      = OP_W'(q_q);
        mul_req.b      = OP_W'(r_sel);
        mul_req.a_wide = 1'b1;
      end
      S_TR: begin
        mul_req.a      = OP_W'(q_q);
        mul_req.b      = OP_W'({1'b0, d2_q});
        mul_req.a_wide = 1'b1;
        mul_req.b_wide = 1'b1;
      end
      default: ;
    endcase
  end

  // One saturating adder serves every accumulator.
  always_comb begin
    case (state_q)
      S_CHG: begin
        add_a = charge_q;
        add_b = SUM_W'(q_q);
      end
      S_DIP: begin
        add_a = dip_sel;
        add_b = mul_rsp.res;
      end
      default: begin
        add_a = trace_q;
        add_b = mul_rsp.res;
      end
    endcase
    add_res = add_sat(add_a, add_b);
  end

  mma_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q[0] <= '0;
      origin_q[1] <= '0;
      origin_q[2] <= '0;
      volume_q    <= VOLUME_RESET;
      density_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_ORIGIN_X:     origin_q[0] <= cfg_data_i;
        CFG_ORIGIN_Y:     origin_q[1] <= cfg_data_i;
        CFG_ORIGIN_Z:     origin_q[2] <= cfg_data_i;
        CFG_VOLUME:       volume_q    <= cfg_data_i;
        CFG_DENSITY_MODE: density_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= 2'd0;
      issued_q    <= 1'b0;
      charge_q    <= '0;
      trace_q     <= '0;
      dip_q[0]    <= '0;
      dip_q[1]    <= '0;
      dip_q[2]    <= '0;
      sat_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_sat_q   <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (mul_req.start) begin
        issued_q <= 1'b1;
      end
      if (mul_rsp.done) begin
        issued_q <= 1'b0;
        sat_q    <= sat_q | mul_rsp.sat;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            last_q  <= s_axis_tlast;
            state_q <= density_q ? S_QMUL : S_CHG;
          end
        end
        S_QMUL: begin
          if (mul_rsp.done) begin
            state_q <= S_CHG;
          end
        end
        S_CHG: begin
          charge_q <= add_res[SUM_W-1:0];
          sat_q    <= sat_q | add_res[SUM_W];
          idx_q    <= 2'd0;
          state_q  <= S_SQ;
        end
        S_SQ: begin
          if (mul_rsp.done) begin
            if (idx_q == 2'd2) begin
              idx_q   <= 2'd0;
              state_q <= S_DIP;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end
        end
        S_DIP: begin
          if (mul_rsp.done) begin
            dip_q[idx_q] <= add_res[SUM_W-1:0];
            sat_q        <= sat_q | mul_rsp.sat | add_res[SUM_W];
            if (idx_q == 2'd2) begin
              idx_q   <= 2'd0;
              state_q <= S_TR;
            end else begin
              idx_q <= idx_q + 2'd1;
            end
          end
        end
        S_TR: begin
          if (mul_rsp.done) begin
            trace_q <= add_res[SUM_W-1:0];
            sat_q   <= sat_q | mul_rsp.sat | add_res[SUM_W];
            state_q <= last_q ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          // Hold until the output register is free, then load and clear the sums.
          if (emit_go) begin
            out_data_q  <= {trace_q, dip_q[2], dip_q[1], dip_q[0], charge_q};
            out_sat_q   <= sat_q;
            out_valid_q <= 1'b1;
            charge_q    <= '0;
            trace_q     <= '0;
            dip_q[0]    <= '0;
            dip_q[1]    <= '0;
            dip_q[2]    <= '0;
            sat_q       <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cd_q   <= s_axis_tdata[IN_W-1:0];
      q_q    <= Q_W'($signed(s_axis_tdata[IN_W-1:0]));
      r_q[0] <= R_W'($signed(s_axis_tdata[2*IN_W-1:IN_W]))   - R_W'(origin_q[0]);
      r_q[1] <= R_W'($signed(s_axis_tdata[3*IN_W-1:2*IN_W])) - R_W'(origin_q[1]);
      r_q[2] <= R_W'($signed(s_axis_tdata[4*IN_W-1:3*IN_W])) - R_W'(origin_q[2]);
    end
    if (state_q == S_QMUL && mul_rsp.done) begin
      q_q <= Q_W'(mul_rsp.res);
    end
    if (state_q == S_CHG) begin
      d2_q <= '0;
    end else if (state_q == S_SQ && mul_rsp.done) begin
      d2_q <= d2_q + D2_W'(mul_rsp.res);
    end
  end

  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;
  assign m_axis_tvalid = out_valid_q;

  a_single_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |=> !mul_req.start)
    else $error("multiplier started on two cycles in a row");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready)
    else $error("input still ready after a beat was taken");

  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_EMIT))
    else $error("output beat raised outside the emit step");

  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> issued_q)
    else $error("multiplier result without an issued product");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the multipole moment accumulator top level.
`timescale 1ns / 100ps

module testbench;
  import mma_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_LEN   = 5;
  localparam int SETTLE_LEN  = 100;   // a few item times of the block
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_LEN    = 400;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 240;
  localparam int PRINT_CAP   = 40;

  localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_UNUSED = CFG_DENSITY_MODE + 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LAST_UNUSED  = {CFG_ADDR_W{1'b1}};

  typedef struct packed {
    logic [SUM_W-1:0] charge;
    logic [SUM_W-1:0] dip_x;
    logic [SUM_W-1:0] dip_y;
    logic [SUM_W-1:0] dip_z;
    logic [SUM_W-1:0] trace;
    logic             sat;
  } moments_t;

  typedef struct {
    bit                    is_reg;
    logic [CFG_ADDR_W-1:0] addr;
    logic [IN_W-1:0]       value;
    logic [IN_W-1:0]       q, x, y, z;
    bit                    last;
    bit                    known;
    moments_t              want;
  } step_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic [4*IN_W-1:0]       s_axis_tdata;
  logic                    s_axis_tlast;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [5*SUM_W-1:0]      m_axis_tdata;
  logic                    m_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_ADDR_W-1:0]   cfg_addr_i;
  logic [IN_W-1:0]         cfg_data_i;

  // predictor copy of the registers and running sums
  logic signed [IN_W-1:0]  org [3];
  logic [IN_W-1:0]         vol_elem;
  logic                    dens_mode;
  logic [SUM_W-1:0]        sum_charge;
  logic [SUM_W-1:0]        sum_dip [3];
  logic [SUM_W-1:0]        sum_trace;
  logic                    sum_sat;

  moments_t                pending_moments [$];
  step_t                   plan [$];
  int                      errors;
  int                      results_seen;
  int                      quiet_cycles;
  bit                      dense_phase;
  int                      set_left;

  multipole_moment_accumulator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    if (errors < PRINT_CAP) begin
      $display("ERROR at %0t: %s", $time, what);
    end
    errors++;
  endtask

  // Exact product, rounded half away from zero to FRAC_BITS, clamped to 64 bits.
  function automatic logic [SUM_W-1:0] round_product(input logic signed [64:0] a,
                                                     input logic signed [64:0] b);
    logic signed [129:0] prod;
    logic [129:0]        mag;
    logic [129:0]        rounded;
    logic                neg;
    neg     = a[64] ^ b[64];
    prod    = a * b;
    mag     = prod[129] ? -prod : prod;
    rounded = (mag + (130'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if ((!neg && rounded > SUM_MAX) || (neg && rounded > SUM_MIN)) begin
      sum_sat = 1'b1;
      return neg ? SUM_MIN : SUM_MAX;
    end
    return neg ? -rounded[SUM_W-1:0] : rounded[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = a + b;
    if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1]) begin
      sum_sat = 1'b1;
      return a[SUM_W-1] ? SUM_MIN : SUM_MAX;
    end
    return s;
  endfunction

  function automatic void apply_reg(input logic [CFG_ADDR_W-1:0] addr,
                                    input logic [IN_W-1:0] value);
    case (addr)
      CFG_ORIGIN_X:     org[0]    = value;
      CFG_ORIGIN_Y:     org[1]    = value;
      CFG_ORIGIN_Z:     org[2]    = value;
      CFG_VOLUME:       vol_elem  = value;
      CFG_DENSITY_MODE: dens_mode = value[0];
      default: ;
    endcase
  endfunction

  function automatic void clear_moments();
    sum_charge = '0;
    sum_trace  = '0;
    sum_sat    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum_dip[i] = '0;
    end
  endfunction

  // Fold one point into the sums; returns 1 with the moments when the set closes.
  function automatic bit accumulate_point(input step_t st, output moments_t m);
    logic signed [64:0]     q;
    logic signed [64:0]     d2;
    logic signed [64:0]     rel [3];
    logic signed [IN_W-1:0] pos [3];
    pos[0] = st.x;
    pos[1] = st.y;
    pos[2] = st.z;
    q = $signed(st.q);
    if (dens_mode) begin
      q = $signed(round_product(q, {33'd0, vol_elem}));
    end
    d2 = '0;
    for (int i = 0; i < 3; i++) begin
      rel[i] = pos[i] - org[i];
      d2 = d2 + $signed(round_product(rel[i], rel[i]));
    end
    sum_charge = add_clamped(sum_charge, q[SUM_W-1:0]);
    for (int i = 0; i < 3; i++) begin
      sum_dip[i] = add_clamped(sum_dip[i], round_product(q, rel[i]));
    end
    sum_trace = add_clamped(sum_trace, round_product(q, d2));
    m = '{sum_charge, sum_dip[0], sum_dip[1], sum_dip[2], sum_trace, sum_sat};
    if (!st.last) begin
      return 1'b0;
    end
    clear_moments();
    return 1'b1;
  endfunction

  // Mostly scaled-down values of either sign, some full width, some extremes.
  function automatic logic [IN_W-1:0] rand_word();
    logic signed [IN_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return v;
      default: return v >>> $urandom_range(4, 22);
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (dense_phase || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic void add_pt(input logic [IN_W-1:0] q, x, y, z, input bit last);
    step_t st;
    st = '{default: '0};
    st.q = q; st.x = x; st.y = y; st.z = z; st.last = last;
    plan.push_back(st);
  endfunction

  function automatic void add_known(input logic [IN_W-1:0] q, x, y, z,
                                    input moments_t want);
    step_t st;
    st = '{default: '0};
    st.q = q; st.x = x; st.y = y; st.z = z; st.last = 1'b1;
    st.known = 1'b1;
    st.want  = want;
    plan.push_back(st);
  endfunction

  function automatic void add_reg(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [IN_W-1:0] value);
    step_t st;
    st = '{default: '0};
    st.is_reg = 1'b1;
    st.addr   = addr;
    st.value  = value;
    plan.push_back(st);
  endfunction

  task automatic feed_point(input step_t st);
    moments_t m;
    int       gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {st.z, st.y, st.x, st.q};
    s_axis_tlast  <= st.last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (accumulate_point(st, m)) begin
      pending_moments.push_back(st.known ? st.want : m);
    end
  endtask

  task automatic program_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [IN_W-1:0] value);
    cfg_addr_i  <= addr;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(addr, value);
  endtask

  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    while (pending_moments.size() != 0) @(posedge clk_i);
  endtask

  // Let a trailing item with no result finish before touching the registers.
  task automatic drain_and_settle();
    wait_results();
    repeat (SETTLE_LEN) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [SUM_W-1:0] got,
                             input logic [SUM_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin : check_results
    moments_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_moments.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = pending_moments.pop_front();
        check_field("total_charge", m_axis_tdata[0*SUM_W +: SUM_W], want.charge);
        check_field("dipole_x", m_axis_tdata[1*SUM_W +: SUM_W], want.dip_x);
        check_field("dipole_y", m_axis_tdata[2*SUM_W +: SUM_W], want.dip_y);
        check_field("dipole_z", m_axis_tdata[3*SUM_W +: SUM_W], want.dip_z);
        check_field("quadrupole_trace", m_axis_tdata[4*SUM_W +: SUM_W], want.trace);
        check_field("saturated", {63'd0, m_axis_tuser}, {63'd0, want.sat});
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("multipole_moment_accumulator_top test failed");
      $finish;
    end
  end

  // Result side: ready bursts and stalls, plus one long hold-off to back up the block.
  initial begin : result_sink
    int  burst;
    int  gap;
    bit  held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      burst = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 10);
      m_axis_tready <= 1'b1;
      repeat (burst) @(posedge clk_i);
      if (!held && results_seen >= 60) begin
        held = 1'b1;
        gap  = HOLD_LEN;
      end else if ($urandom_range(0, 99) < 85) begin
        gap = $urandom_range(1, 3);
      end else begin
        gap = $urandom_range(20, 80);
      end
      m_axis_tready <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    step_t st;
    bit    reg_burst;
    bit    paused;
    int    mode_pick;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tvalid = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = '0;
    cfg_data_i    = '0;
    errors        = 0;
    results_seen  = 0;
    quiet_cycles  = 0;
    dense_phase   = 1'b0;
    set_left      = 0;
    org[0] = '0; org[1] = '0; org[2] = '0;
    vol_elem  = VOLUME_RESET;
    dens_mode = 1'b0;
    clear_moments();

    // default registers: charge mode, origin at zero, unit volume
    add_known(32'h0, 32'h0, 32'h0, 32'h0, '{64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b0});
    add_known(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0,
              '{64'h1_0000, 64'h1_0000, 64'h0, 64'h0, 64'h1_0000, 1'b0});
    add_known(32'hFFFF_0000, 32'h0, 32'hFFFF_0000, 32'h0002_0000,
              '{64'hFFFF_FFFF_FFFF_0000, 64'h0, 64'h1_0000,
                64'hFFFF_FFFF_FFFE_0000, 64'hFFFF_FFFF_FFFB_0000, 1'b0});
    // half-LSB products round away from zero on both signs
    add_known(32'h1, 32'h8000, 32'h0, 32'h0, '{64'h1, 64'h1, 64'h0, 64'h0, 64'h0, 1'b0});
    add_known(32'hFFFF_FFFF, 32'h8000, 32'h0, 32'h0,
              '{{SUM_W{1'b1}}, {SUM_W{1'b1}}, 64'h0, 64'h0, 64'h0, 1'b0});
    add_pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    add_pt(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    // trace sum overflows without any single product overflowing
    add_pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_pt(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    add_pt(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    add_pt(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
    // origin x and y at the extremes
    add_reg(CFG_ORIGIN_X, 32'h7FFF_FFFF);
    add_reg(CFG_ORIGIN_Y, 32'h8000_0000);
    add_reg(CFG_ORIGIN_Z, 32'h1234_5678);
    add_pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1);
    add_pt(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    // densities with the largest volume element
    add_reg(CFG_DENSITY_MODE, 32'h1);
    add_reg(CFG_VOLUME, 32'hFFFF_FFFF);
    add_pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b0);
    add_pt(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1);
    add_pt(32'h0000_8000, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 1'b1);
    // zero volume element turns every density into zero charge
    add_reg(CFG_VOLUME, 32'h0);
    add_known(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678,
              '{64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b0});
    // unused indexes must not disturb anything; then back to defaults
    add_reg(CFG_FIRST_UNUSED, 32'hFFFF_FFFF);
    add_reg(CFG_LAST_UNUSED, 32'hFFFF_FFFF);
    add_reg(CFG_ORIGIN_X, 32'h0);
    add_reg(CFG_ORIGIN_Y, 32'h0);
    add_reg(CFG_ORIGIN_Z, 32'h0);
    add_reg(CFG_VOLUME, VOLUME_RESET);
    add_reg(CFG_DENSITY_MODE, 32'h0);
    add_known(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0,
              '{64'h1_0000, 64'h1_0000, 64'h0, 64'h0, 64'h1_0000, 1'b0});

    repeat (RESET_LEN) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    reg_burst = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!reg_burst) begin
          drain_and_settle();
        end
        program_reg(plan[i].addr, plan[i].value);
        reg_burst = 1'b1;
      end else begin
        if (reg_burst) begin
          cfg_valid_i <= 1'b0;
        end
        reg_burst = 1'b0;
        feed_point(plan[i]);
      end
    end

    paused = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      program_reg(CFG_ORIGIN_X, p == 0 ? 32'h0 : rand_word());
      program_reg(CFG_ORIGIN_Y, p == 0 ? 32'h0 : rand_word());
      program_reg(CFG_ORIGIN_Z, p == 0 ? 32'h0 : rand_word());
      if (p == 1) begin
        program_reg(CFG_ORIGIN_X, $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
        program_reg(CFG_ORIGIN_Y, $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
      end
      case (p)
        0:       program_reg(CFG_VOLUME, VOLUME_RESET);
        2:       program_reg(CFG_VOLUME, 32'h1);
        3:       program_reg(CFG_VOLUME, 32'hFFFF_FFFF);
        5:       program_reg(CFG_VOLUME, 32'h0);
        default: program_reg(CFG_VOLUME, $urandom_range(0, 1) ? $urandom
                                                             : $urandom_range(0, 1 << 20));
      endcase
      mode_pick = (p < 2) ? 0 : (p < 6) ? 1 : $urandom_range(0, 1);
      program_reg(CFG_DENSITY_MODE, mode_pick);
      program_reg($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED), $urandom);
      cfg_valid_i <= 1'b0;
      dense_phase = (p % 3 == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (set_left == 0) begin
          mode_pick = $urandom_range(0, 99);
          set_left  = (mode_pick < 70) ? $urandom_range(1, 6) :
                      (mode_pick < 95) ? $urandom_range(7, 30) : $urandom_range(31, 120);
        end
        st = '{default: '0};
        st.q    = rand_word();
        st.x    = rand_word();
        st.y    = rand_word();
        st.z    = rand_word();
        st.last = (set_left == 1);
        set_left--;
        feed_point(st);
        // hold the sender until the outstanding results are all back
        if (p == 4 && n >= 120 && st.last && !paused) begin
          paused = 1'b1;
          wait_results();
        end
      end
    end

    wait_results();
    repeat (SETTLE_LEN) @(posedge clk_i);
    if (pending_moments.size() != 0) begin
      report_mismatch("expected results never arrived");
    end
    if (errors == 0) begin
      $display("multipole_moment_accumulator_top test passed");
    end else begin
      $display("multipole_moment_accumulator_top test failed");
    end
    $finish;
  end

endmodule
